### sv/i2cm_pkg.sv
// Shared types and constants for the I2C master bit engine.
// Used by i2cm_core and i2c_master_bit_engine; depends on nothing else.
package i2cm_pkg;

  // Widths of configuration, delay and counter fields.
  localparam int unsigned CfgW   = 10;
  localparam int unsigned DelayW = CfgW + 2;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned BitCntW = 4;

  // Reset values of the configuration registers.
  localparam logic [CfgW-1:0] TicksPerUsReset = 10'd100;
  localparam logic [CfgW-1:0] AckTimeoutReset = 10'd250;

  // Number of data bits in one byte transfer.
  localparam logic [BitCntW-1:0] BitsPerByte = 4'd8;

  // Configuration register indexes.
  localparam logic CFG_TICKS_PER_US = 1'b0;
  localparam logic CFG_ACK_TIMEOUT  = 1'b1;

  // Command codes carried by the mode field.
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_WAIT  = 3'd5
  } cmd_t;

  // Line sequencer phases.
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_ST_SDA  = 4'd1,
    PH_ST_SCL  = 4'd2,
    PH_SP_SCL  = 4'd3,
    PH_SP_SDA  = 4'd4,
    PH_WA_SCL  = 4'd5,
    PH_WA_POLL = 4'd6,
    PH_TX_HIGH = 4'd7,
    PH_TX_LOW  = 4'd8,
    PH_TX_NEXT = 4'd9,
    PH_RX_HIGH = 4'd10,
    PH_RX_NEXT = 4'd11,
    PH_AK_HIGH = 4'd12,
    PH_AK_LOW  = 4'd13
  } phase_t;

  // Line and status values produced for one tick.
  typedef struct packed {
    logic             scl_level;
    logic             sda_level;
    logic             sda_enable;
    logic             busy;
    logic             done;
    logic [ByteW-1:0] rx_byte;
    logic             ack_failed;
  } res_t;

endpackage

### sv/i2cm_core.sv
// Line sequencer core: holds the I2C phase state and advances it by one tick.
// Depends on i2cm_pkg for the phase enum, command codes and result struct.
module i2cm_core import i2cm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [2:0]       mode,
  input  logic [ByteW-1:0] tx_byte,
  input  logic             send_ack,
  input  logic             sda_in,
  input  logic [CfgW-1:0]  ticks_per_us,
  input  logic [CfgW-1:0]  ack_timeout,
  output res_t             res
);

  phase_t             phase, phase_next;
  logic [BitCntW-1:0] bit_index, bit_index_next;
  logic [ByteW-1:0]   shift_reg, shift_reg_next;
  logic [DelayW-1:0]  delay_left, delay_left_next;
  logic [CfgW-1:0]    poll_count, poll_count_next;
  logic [2:0]         active_cmd, active_cmd_next;
  logic               ack_choice, ack_choice_next;
  logic               scl_reg, scl_reg_next;
  logic               sda_reg, sda_reg_next;
  logic               sda_oe_reg, sda_oe_reg_next;
  logic               fail_reg, fail_reg_next;
  logic [ByteW-1:0]   rx_hold, rx_hold_next;
  logic               done_now;

  logic [CfgW-1:0]    tick_unit;
  logic [DelayW-1:0]  dly1, dly2, dly4;
  logic [CfgW:0]      poll_inc;

  // Delay lengths of one, two and four microseconds; a zero setting acts as one.
  always_comb begin
    tick_unit = (ticks_per_us == '0) ? CfgW'(1) : ticks_per_us;
    dly1      = {2'b00, tick_unit};
    dly2      = {1'b0, tick_unit, 1'b0};
    dly4      = {tick_unit, 2'b00};
    poll_inc  = {1'b0, poll_count} + (CfgW+1)'(1);
  end

  // Next-state logic for one tick.
  always_comb begin
    phase_next      = phase;
    bit_index_next  = bit_index;
    shift_reg_next  = shift_reg;
    delay_left_next = delay_left;
    poll_count_next = poll_count;
    active_cmd_next = active_cmd;
    ack_choice_next = ack_choice;
    scl_reg_next    = scl_reg;
    sda_reg_next    = sda_reg;
    sda_oe_reg_next = sda_oe_reg;
    fail_reg_next   = fail_reg;
    rx_hold_next    = rx_hold;
    done_now        = 1'b0;

    if (phase == PH_IDLE) begin
      // A new command is taken only while idle.
      if (mode >= CMD_START && mode <= CMD_WAIT) begin
        active_cmd_next = mode;
        fail_reg_next   = 1'b0;
        case (mode)
          CMD_START: begin
            sda_oe_reg_next = 1'b1;
            sda_reg_next    = 1'b1;
            scl_reg_next    = 1'b1;
            phase_next      = PH_ST_SDA;
            delay_left_next = dly4;
          end
          CMD_STOP: begin
            sda_oe_reg_next = 1'b1;
            scl_reg_next    = 1'b0;
            sda_reg_next    = 1'b0;
            phase_next      = PH_SP_SCL;
            delay_left_next = dly4;
          end
          CMD_WRITE: begin
            sda_oe_reg_next = 1'b1;
            scl_reg_next    = 1'b0;
            sda_reg_next    = tx_byte[ByteW-1];
            shift_reg_next  = {tx_byte[ByteW-2:0], 1'b0};
            bit_index_next  = BitCntW'(1);
            phase_next      = PH_TX_HIGH;
            delay_left_next = dly2;
          end
          CMD_READ: begin
            ack_choice_next = send_ack;
            sda_oe_reg_next = 1'b0;
            shift_reg_next  = '0;
            bit_index_next  = '0;
            scl_reg_next    = 1'b0;
            phase_next      = PH_RX_HIGH;
            delay_left_next = dly2;
          end
          default: begin
            sda_oe_reg_next = 1'b0;
            sda_reg_next    = 1'b1;
            poll_count_next = '0;
            phase_next      = PH_WA_SCL;
            delay_left_next = dly1;
          end
        endcase
      end
    end else if (delay_left > DelayW'(1)) begin
      delay_left_next = delay_left - DelayW'(1);
    end else begin
      // Delay elapsed: make the next line change.
      case (phase)
        PH_ST_SDA: begin
          sda_reg_next    = 1'b0;
          phase_next      = PH_ST_SCL;
          delay_left_next = dly4;
        end
        PH_ST_SCL: begin
          scl_reg_next    = 1'b0;
          phase_next      = PH_IDLE;
          delay_left_next = '0;
          done_now        = 1'b1;
        end
        PH_SP_SCL: begin
          scl_reg_next    = 1'b1;
          phase_next      = PH_SP_SDA;
          delay_left_next = dly4;
        end
        PH_SP_SDA: begin
          sda_reg_next    = 1'b1;
          if (active_cmd == CMD_WAIT) begin
            fail_reg_next = 1'b1;
          end
          phase_next      = PH_IDLE;
          delay_left_next = '0;
          done_now        = 1'b1;
        end
        PH_WA_SCL: begin
          scl_reg_next    = 1'b1;
          phase_next      = PH_WA_POLL;
          delay_left_next = dly1;
        end
        PH_WA_POLL: begin
          if (!sda_in) begin
            scl_reg_next    = 1'b0;
            phase_next      = PH_IDLE;
            delay_left_next = '0;
            done_now        = 1'b1;
          end else if (poll_inc > {1'b0, ack_timeout}) begin
            // Timed out: issue a stop condition.
            sda_oe_reg_next = 1'b1;
            scl_reg_next    = 1'b0;
            sda_reg_next    = 1'b0;
            phase_next      = PH_SP_SCL;
            delay_left_next = dly4;
          end else begin
            poll_count_next = poll_inc[CfgW-1:0];
            delay_left_next = '0;
          end
        end
        PH_TX_HIGH: begin
          scl_reg_next    = 1'b1;
          phase_next      = PH_TX_LOW;
          delay_left_next = dly2;
        end
        PH_TX_LOW: begin
          scl_reg_next    = 1'b0;
          phase_next      = PH_TX_NEXT;
          delay_left_next = dly2;
        end
        PH_TX_NEXT: begin
          if (bit_index >= BitsPerByte) begin
            phase_next      = PH_IDLE;
            delay_left_next = '0;
            done_now        = 1'b1;
          end else begin
            sda_reg_next    = shift_reg[ByteW-1];
            shift_reg_next  = {shift_reg[ByteW-2:0], 1'b0};
            bit_index_next  = bit_index + BitCntW'(1);
            phase_next      = PH_TX_HIGH;
            delay_left_next = dly2;
          end
        end
        PH_RX_HIGH: begin
          // Sample the data bit as SCL rises.
          scl_reg_next    = 1'b1;
          shift_reg_next  = {shift_reg[ByteW-2:0], sda_in};
          bit_index_next  = bit_index + BitCntW'(1);
          phase_next      = PH_RX_NEXT;
          delay_left_next = dly1;
        end
        PH_RX_NEXT: begin
          scl_reg_next = 1'b0;
          if (bit_index >= BitsPerByte) begin
            rx_hold_next    = shift_reg;
            sda_oe_reg_next = 1'b1;
            sda_reg_next    = ~ack_choice;
            phase_next      = PH_AK_HIGH;
          end else begin
            phase_next      = PH_RX_HIGH;
          end
          delay_left_next = dly2;
        end
        PH_AK_HIGH: begin
          scl_reg_next    = 1'b1;
          phase_next      = PH_AK_LOW;
          delay_left_next = dly2;
        end
        PH_AK_LOW: begin
          scl_reg_next    = 1'b0;
          phase_next      = PH_IDLE;
          delay_left_next = '0;
          done_now        = 1'b1;
        end
        default: begin
          phase_next      = PH_IDLE;
          delay_left_next = '0;
          done_now        = 1'b1;
        end
      endcase
    end
  end

  // Values after this tick's update form the result.
  always_comb begin
    res.scl_level  = scl_reg_next;
    res.sda_level  = sda_reg_next;
    res.sda_enable = sda_oe_reg_next;
    res.busy       = (phase_next != PH_IDLE);
    res.done       = done_now;
    res.rx_byte    = rx_hold_next;
    res.ack_failed = fail_reg_next;
  end

  // State registers advance once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_index  <= '0;
      shift_reg  <= '0;
      delay_left <= '0;
      poll_count <= '0;
      active_cmd <= CMD_NONE;
      ack_choice <= 1'b0;
      scl_reg    <= 1'b1;
      sda_reg    <= 1'b1;
      sda_oe_reg <= 1'b1;
      fail_reg   <= 1'b0;
      rx_hold    <= '0;
    end else if (step) begin
      phase      <= phase_next;
      bit_index  <= bit_index_next;
      shift_reg  <= shift_reg_next;
      delay_left <= delay_left_next;
      poll_count <= poll_count_next;
      active_cmd <= active_cmd_next;
      ack_choice <= ack_choice_next;
      scl_reg    <= scl_reg_next;
      sda_reg    <= sda_reg_next;
      sda_oe_reg <= sda_oe_reg_next;
      fail_reg   <= fail_reg_next;
      rx_hold    <= rx_hold_next;
    end
  end

endmodule

### sv/i2c_master_bit_engine.sv
// I2C master bit engine top level: configuration registers, input handshake
// and result register around the line sequencer. Depends on i2cm_pkg, i2cm_core.
//
// Usage: each input beat is one tick of line timing. It carries an optional
// command (mode, tx_byte, send_ack) and the sampled SDA level. A command is
// taken only while the sequencer is idle; commands given while busy are ignored.
// Each input beat produces exactly one output beat with the SCL level, SDA
// level and enable, busy, done, the last received byte and the ACK-failure flag.
// The result of a beat is registered and is valid in the cycle after the beat
// is accepted. Throughput is one beat per cycle while the receiver takes each
// result. in_ready is high while the result register is empty or being
// drained, so a stalled receiver holds the result and stops further input
// until it takes the beat. Reset idles the sequencer with SCL high and SDA
// driven high, and loads ticks_per_us = 100 and ack_timeout = 250.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
// the user must make them while no tick is in flight (not enforced here).
module i2c_master_bit_engine import i2cm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CfgW-1:0]  cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       mode,
  input  logic [ByteW-1:0] tx_byte,
  input  logic             send_ack,
  input  logic             sda_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             scl_level,
  output logic             sda_level,
  output logic             sda_enable,
  output logic             busy_res,
  output logic             done_res,
  output logic [ByteW-1:0] rx_byte,
  output logic             ack_failed
);

  logic [CfgW-1:0] ticks_per_us;
  logic [CfgW-1:0] ack_timeout;
  logic            in_fire;
  res_t            core_res;
  res_t            out_res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_us <= TicksPerUsReset;
      ack_timeout  <= AckTimeoutReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICKS_PER_US: ticks_per_us <= cfg_data;
        CFG_ACK_TIMEOUT:  ack_timeout  <= cfg_data;
        default:          ticks_per_us <= ticks_per_us;
      endcase
    end
  end

  // Input beat is taken whenever the result register can be refilled.
  assign in_ready = ~out_valid | out_ready;
  assign in_fire  = in_valid & in_ready;

  i2cm_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (in_fire),
    .mode         (mode),
    .tx_byte      (tx_byte),
    .send_ack     (send_ack),
    .sda_in       (sda_in),
    .ticks_per_us (ticks_per_us),
    .ack_timeout  (ack_timeout),
    .res          (core_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_res <= core_res;
    end
  end

  assign scl_level  = out_res.scl_level;
  assign sda_level  = out_res.sda_level;
  assign sda_enable = out_res.sda_enable;
  assign busy_res   = out_res.busy;
  assign done_res   = out_res.done;
  assign rx_byte    = out_res.rx_byte;
  assign ack_failed = out_res.ack_failed;

endmodule
